>>> src/i14a_pkg.sv
// Shared types, codes and the CRC_A byte step for the type A poller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package i14a_pkg;

    localparam int MAX_CASCADE_LEVELS = 3;
    localparam int UID_DEPTH          = 10;

    // Commands and link events
    localparam logic [2:0] CMD_ACTIVATE = 3'd0;
    localparam logic [2:0] CMD_HALT     = 3'd1;
    localparam logic [2:0] CMD_PRESENCE = 3'd2;
    localparam logic [2:0] CMD_RESP     = 3'd3;
    localparam logic [2:0] CMD_TIMEOUT  = 3'd4;
    localparam logic [2:0] CMD_LINK_ERR = 3'd5;

    // Exchange phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_HALT_ACT = 4'd1;
    localparam logic [3:0] PH_ATQA     = 4'd2;
    localparam logic [3:0] PH_SDD      = 4'd3;
    localparam logic [3:0] PH_SAK      = 4'd4;
    localparam logic [3:0] PH_HALT     = 4'd5;
    localparam logic [3:0] PH_PRESENCE = 4'd6;

    // Link states
    localparam logic [1:0] LS_IDLE      = 2'd0;
    localparam logic [1:0] LS_RESOLVING = 2'd1;
    localparam logic [1:0] LS_ACTIVE    = 2'd2;
    localparam logic [1:0] LS_FAILED    = 2'd3;

    // Result kinds
    localparam logic [2:0] K_SHORT   = 3'd0;
    localparam logic [2:0] K_ANTICOL = 3'd1;
    localparam logic [2:0] K_STD     = 3'd2;
    localparam logic [2:0] K_UID     = 3'd3;
    localparam logic [2:0] K_STATUS  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_PRESENT = 3'd1;
    localparam logic [2:0] ST_COMM        = 3'd2;
    localparam logic [2:0] ST_COLRES      = 3'd3;
    localparam logic [2:0] ST_TIMEOUT     = 3'd4;

    // Output run types
    localparam logic [2:0] RUN_REQA = 3'd0;
    localparam logic [2:0] RUN_HLTA = 3'd1;
    localparam logic [2:0] RUN_SDD  = 3'd2;
    localparam logic [2:0] RUN_SEL  = 3'd3;
    localparam logic [2:0] RUN_UID  = 3'd4;
    localparam logic [2:0] RUN_STAT = 3'd5;

    localparam logic [7:0]  REQA_BYTE = 8'h26;
    localparam logic [7:0]  HLTA_B0   = 8'h50;
    localparam logic [7:0]  HLTA_B1   = 8'h00;
    localparam logic [7:0]  SEL_BASE  = 8'h93;
    localparam logic [7:0]  NVB_SDD   = 8'h20;
    localparam logic [7:0]  NVB_SEL   = 8'h70;
    localparam logic [7:0]  CT_BYTE   = 8'h88;
    localparam logic [15:0] CRC_PRESET = 16'h6363;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] rx_len;
        logic [7:0] rx_byte0;
        logic [7:0] rx_byte1;
        logic [7:0] rx_byte2;
        logic [7:0] rx_byte3;
        logic [7:0] rx_byte4;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic        last;
        logic [2:0]  status;
        logic [15:0] atqa_out;
        logic [7:0]  sak_out;
        logic [3:0]  uid_count;
    } out_beat_t;

    // Controller to datapath
    typedef struct packed {
        logic       clear_act;
        logic       store_atqa;
        logic       store_nfcid;
        logic       push_casc;
        logic       push_final;
        logic       start;
        logic [2:0] run;
        logic [2:0] stat;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;
        logic sak_crc_ok;
        logic nfcid_is_ct;
        logic casc_blocked;
        logic final_blocked;
    } dp_sts_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b_in);
        logic [7:0] b;
        b = b_in ^ crc[7:0];
        b = b ^ {b[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {b, 8'h00} ^ {5'b00000, b, 3'b000} ^ {12'h000, b[7:4]};
    endfunction

endpackage

>>> src/i14a_dp.sv
// Datapath: activation registers, UID store, CRC_A engine, run emitter and
// output register. Depends on i14a_pkg.
`timescale 1ns / 1ps
module i14a_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  i14a_pkg::in_beat_t   in_data,
    input  i14a_pkg::dp_cmd_t    cmd,
    output i14a_pkg::dp_sts_t    sts,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i14a_pkg::out_beat_t  out_data
);

    logic [15:0] atqa_reg;
    logic [7:0]  sak_reg;
    logic [3:0]  fill_reg;
    logic [1:0]  casc_reg;
    logic [7:0]  bcc_reg;
    logic [7:0]  nfcid [4];
    logic [7:0]  uid_store [i14a_pkg::UID_DEPTH];

    logic        busy_reg;
    logic [2:0]  run_reg;
    logic [2:0]  stat_reg;
    logic [3:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        out_valid_reg;
    i14a_pkg::out_beat_t out_reg;

    logic [7:0]  sel_code;
    logic [7:0]  data_byte;
    logic [3:0]  n_data;
    logic [3:0]  nf_off;
    logic [3:0]  crc_hi_idx;
    logic        is_data;
    logic        load;
    i14a_pkg::out_beat_t beat;

    assign sel_code   = i14a_pkg::SEL_BASE + {5'b00000, casc_reg, 1'b0};
    assign nf_off     = idx_reg - 4'd2;
    assign is_data    = idx_reg < n_data;
    assign crc_hi_idx = n_data + 4'd1;
    assign load       = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        n_data    = 4'd0;
        data_byte = 8'h00;
        beat.kind      = i14a_pkg::K_STD;
        beat.value     = 8'h00;
        beat.last      = 1'b0;
        beat.status    = i14a_pkg::ST_OK;
        beat.atqa_out  = atqa_reg;
        beat.sak_out   = sak_reg;
        beat.uid_count = fill_reg;
        unique case (run_reg)
            i14a_pkg::RUN_REQA:
            begin
                beat.kind  = i14a_pkg::K_SHORT;
                beat.value = i14a_pkg::REQA_BYTE;
                beat.last  = 1'b1;
            end
            i14a_pkg::RUN_HLTA, i14a_pkg::RUN_SEL:
            begin
                if (run_reg == i14a_pkg::RUN_HLTA)
                begin
                    n_data    = 4'd2;
                    data_byte = (idx_reg == 4'd0) ? i14a_pkg::HLTA_B0 : i14a_pkg::HLTA_B1;
                end
                else
                begin
                    n_data = 4'd7;
                    if (idx_reg == 4'd0)
                        data_byte = sel_code;
                    else if (idx_reg == 4'd1)
                        data_byte = i14a_pkg::NVB_SEL;
                    else if (idx_reg == 4'd6)
                        data_byte = bcc_reg;
                    else
                        data_byte = nfcid[nf_off[1:0]];
                end
                if (idx_reg < n_data)
                    beat.value = data_byte;
                else if (idx_reg == n_data)
                    beat.value = crc_reg[7:0];
                else
                    beat.value = crc_reg[15:8];
                beat.last = (idx_reg == crc_hi_idx);
            end
            i14a_pkg::RUN_SDD:
            begin
                beat.kind  = i14a_pkg::K_ANTICOL;
                beat.value = (idx_reg == 4'd0) ? sel_code : i14a_pkg::NVB_SDD;
                beat.last  = (idx_reg == 4'd1);
            end
            i14a_pkg::RUN_UID:
            begin
                if (idx_reg < fill_reg)
                begin
                    beat.kind  = i14a_pkg::K_UID;
                    beat.value = uid_store[idx_reg];
                end
                else
                begin
                    beat.kind = i14a_pkg::K_STATUS;
                    beat.last = 1'b1;
                end
            end
            default:
            begin
                beat.kind   = i14a_pkg::K_STATUS;
                beat.status = stat_reg;
                beat.last   = 1'b1;
            end
        endcase
    end

    // Emitter control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
                busy_reg <= 1'b1;
            else if (load && beat.last)
                busy_reg <= 1'b0;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Emitter payload: advance index, fold data bytes into the CRC
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            run_reg  <= cmd.run;
            stat_reg <= cmd.stat;
            idx_reg  <= 4'd0;
            crc_reg  <= i14a_pkg::CRC_PRESET;
        end
        else if (load)
        begin
            idx_reg <= idx_reg + 4'd1;
            if (is_data)
                crc_reg <= i14a_pkg::crc_step(crc_reg, data_byte);
        end
        if (load)
            out_reg <= beat;
    end

    // Activation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atqa_reg <= 16'h0000;
            sak_reg  <= 8'h00;
            fill_reg <= 4'd0;
            casc_reg <= 2'd0;
            bcc_reg  <= 8'h00;
        end
        else
        begin
            if (cmd.clear_act)
            begin
                atqa_reg <= 16'h0000;
                sak_reg  <= 8'h00;
                fill_reg <= 4'd0;
                casc_reg <= 2'd0;
                bcc_reg  <= 8'h00;
            end
            if (cmd.store_atqa)
            begin
                atqa_reg <= {in_data.rx_byte1, in_data.rx_byte0};
                casc_reg <= 2'd0;
            end
            if (cmd.store_nfcid)
                bcc_reg <= in_data.rx_byte4;
            if (cmd.push_casc)
            begin
                fill_reg <= fill_reg + 4'd3;
                casc_reg <= casc_reg + 2'd1;
            end
            if (cmd.push_final)
            begin
                fill_reg <= fill_reg + 4'd4;
                sak_reg  <= in_data.rx_byte0;
            end
        end
    end

    // NFCID and UID stores, written only when filled
    always_ff @(posedge clk)
    begin
        if (cmd.store_nfcid)
        begin
            nfcid[0] <= in_data.rx_byte0;
            nfcid[1] <= in_data.rx_byte1;
            nfcid[2] <= in_data.rx_byte2;
            nfcid[3] <= in_data.rx_byte3;
        end
        if (cmd.push_casc)
        begin
            uid_store[fill_reg]         <= nfcid[1];
            uid_store[fill_reg + 4'd1]  <= nfcid[2];
            uid_store[fill_reg + 4'd2]  <= nfcid[3];
        end
        if (cmd.push_final)
        begin
            uid_store[fill_reg]         <= nfcid[0];
            uid_store[fill_reg + 4'd1]  <= nfcid[1];
            uid_store[fill_reg + 4'd2]  <= nfcid[2];
            uid_store[fill_reg + 4'd3]  <= nfcid[3];
        end
    end

    assign sts.busy          = busy_reg;
    assign sts.sak_crc_ok    = i14a_pkg::crc_step(i14a_pkg::CRC_PRESET, in_data.rx_byte0)
                               == {in_data.rx_byte2, in_data.rx_byte1};
    assign sts.nfcid_is_ct   = (nfcid[0] == i14a_pkg::CT_BYTE);
    assign sts.casc_blocked  = ({1'b0, casc_reg} + 3'd1 >= 3'(i14a_pkg::MAX_CASCADE_LEVELS))
                               || ({1'b0, fill_reg} + 5'd3 > 5'(i14a_pkg::UID_DEPTH));
    assign sts.final_blocked = ({1'b0, fill_reg} + 5'd4 > 5'(i14a_pkg::UID_DEPTH));

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> src/i14a_ctrl.sv
// Controller: exchange phase and link state machine; decides each event.
// Depends on i14a_pkg.
`timescale 1ns / 1ps
module i14a_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  i14a_pkg::in_beat_t  in_data,
    input  i14a_pkg::dp_sts_t   sts,
    output i14a_pkg::dp_cmd_t   cmd
);

    logic [3:0] phase_reg, phase_next;
    logic [1:0] link_reg, link_next;

    always_comb
    begin
        phase_next = phase_reg;
        link_next  = link_reg;
        cmd        = '0;
        if (accept)
        begin
            priority if (in_data.command == i14a_pkg::CMD_ACTIVATE)
            begin
                cmd.clear_act = 1'b1;
                cmd.start     = 1'b1;
                if (link_reg != i14a_pkg::LS_IDLE)
                begin
                    phase_next = i14a_pkg::PH_HALT_ACT;
                    cmd.run    = i14a_pkg::RUN_HLTA;
                end
                else
                begin
                    phase_next = i14a_pkg::PH_ATQA;
                    cmd.run    = i14a_pkg::RUN_REQA;
                end
            end
            else if (in_data.command == i14a_pkg::CMD_HALT)
            begin
                phase_next = i14a_pkg::PH_HALT;
                cmd.start  = 1'b1;
                cmd.run    = i14a_pkg::RUN_HLTA;
            end
            else if (in_data.command == i14a_pkg::CMD_PRESENCE)
            begin
                phase_next = i14a_pkg::PH_PRESENCE;
                cmd.start  = 1'b1;
                cmd.run    = i14a_pkg::RUN_REQA;
            end
            else if (in_data.command > i14a_pkg::CMD_LINK_ERR || phase_reg == i14a_pkg::PH_IDLE)
            begin
                // drop: unknown code or nothing pending
            end
            else
            begin
                unique case (phase_reg)
                    i14a_pkg::PH_HALT_ACT:
                    begin
                        link_next  = i14a_pkg::LS_IDLE;
                        phase_next = i14a_pkg::PH_ATQA;
                        cmd.start  = 1'b1;
                        cmd.run    = i14a_pkg::RUN_REQA;
                    end
                    i14a_pkg::PH_HALT:
                    begin
                        link_next  = i14a_pkg::LS_IDLE;
                        phase_next = i14a_pkg::PH_IDLE;
                        cmd.start  = 1'b1;
                        cmd.run    = i14a_pkg::RUN_STAT;
                        cmd.stat   = i14a_pkg::ST_OK;
                    end
                    i14a_pkg::PH_PRESENCE:
                    begin
                        phase_next = i14a_pkg::PH_IDLE;
                        cmd.start  = 1'b1;
                        cmd.run    = i14a_pkg::RUN_STAT;
                        if (in_data.command == i14a_pkg::CMD_TIMEOUT)
                            cmd.stat = i14a_pkg::ST_TIMEOUT;
                        else if (in_data.command == i14a_pkg::CMD_LINK_ERR)
                            cmd.stat = i14a_pkg::ST_NOT_PRESENT;
                        else if (in_data.rx_len != 3'd2)
                            cmd.stat = i14a_pkg::ST_COMM;
                        else
                            cmd.stat = i14a_pkg::ST_OK;
                    end
                    i14a_pkg::PH_ATQA:
                    begin
                        cmd.start = 1'b1;
                        if (in_data.command != i14a_pkg::CMD_RESP)
                        begin
                            phase_next = i14a_pkg::PH_IDLE;
                            cmd.run    = i14a_pkg::RUN_STAT;
                            cmd.stat   = i14a_pkg::ST_NOT_PRESENT;
                        end
                        else if (in_data.rx_len != 3'd2)
                        begin
                            phase_next = i14a_pkg::PH_IDLE;
                            cmd.run    = i14a_pkg::RUN_STAT;
                            cmd.stat   = i14a_pkg::ST_COMM;
                        end
                        else
                        begin
                            cmd.store_atqa = 1'b1;
                            link_next      = i14a_pkg::LS_RESOLVING;
                            phase_next     = i14a_pkg::PH_SDD;
                            cmd.run        = i14a_pkg::RUN_SDD;
                        end
                    end
                    i14a_pkg::PH_SDD:
                    begin
                        cmd.start = 1'b1;
                        if (in_data.command != i14a_pkg::CMD_RESP || in_data.rx_len != 3'd5)
                        begin
                            link_next  = i14a_pkg::LS_FAILED;
                            phase_next = i14a_pkg::PH_IDLE;
                            cmd.run    = i14a_pkg::RUN_STAT;
                            cmd.stat   = i14a_pkg::ST_COLRES;
                        end
                        else
                        begin
                            cmd.store_nfcid = 1'b1;
                            phase_next      = i14a_pkg::PH_SAK;
                            cmd.run         = i14a_pkg::RUN_SEL;
                        end
                    end
                    i14a_pkg::PH_SAK:
                    begin
                        cmd.start = 1'b1;
                        if (in_data.command != i14a_pkg::CMD_RESP || in_data.rx_len != 3'd3
                            || !sts.sak_crc_ok
                            || (sts.nfcid_is_ct && sts.casc_blocked)
                            || (!sts.nfcid_is_ct && sts.final_blocked))
                        begin
                            link_next  = i14a_pkg::LS_FAILED;
                            phase_next = i14a_pkg::PH_IDLE;
                            cmd.run    = i14a_pkg::RUN_STAT;
                            cmd.stat   = i14a_pkg::ST_COLRES;
                        end
                        else if (sts.nfcid_is_ct)
                        begin
                            cmd.push_casc = 1'b1;
                            phase_next    = i14a_pkg::PH_SDD;
                            cmd.run       = i14a_pkg::RUN_SDD;
                        end
                        else
                        begin
                            cmd.push_final = 1'b1;
                            link_next      = i14a_pkg::LS_ACTIVE;
                            phase_next     = i14a_pkg::PH_IDLE;
                            cmd.run        = i14a_pkg::RUN_UID;
                        end
                    end
                    default:
                    begin
                        phase_next = i14a_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i14a_pkg::PH_IDLE;
            link_reg  <= i14a_pkg::LS_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
            link_reg  <= link_next;
        end
    end

endmodule

>>> src/iso14443a_anticollision_poller.sv
// Top level of the ISO 14443-3A reader activation sequencer.
// Depends on i14a_pkg, i14a_ctrl and i14a_dp.
`timescale 1ns / 1ps
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat per command or link
//     event (activate, halt, presence check, response, timeout, link error).
//   out channel (out_valid/out_ready/out_data): the frames to transmit as
//     byte beats (CRC_A appended here), UID bytes and status beats; the
//     final beat of each run has last set. A run holds 1 to 11 beats.
//   An event is decided in the cycle it is accepted; the emitter registers
//     its run, the output register then takes the first beat, and after it
//     one beat per cycle while out_ready stays high. Beats come from the
//     serial run emitter.
//   in_ready is high whenever no run is being emitted; the last beat of a
//     run may still wait in the output register while the next event is
//     taken.
//   When the receiver stalls, the output register holds its beat and the
//     emitter waits; in_ready stays low until the run is fully loaded.
//   Reset clears the phase to idle, link state to idle, cascade level, UID
//   count, ATQA and SAK; NFCID and UID stores are filled before use.
module iso14443a_anticollision_poller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i14a_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i14a_pkg::out_beat_t  out_data
);

    i14a_pkg::dp_cmd_t cmd;
    i14a_pkg::dp_sts_t sts;
    logic              accept;

    // Take a new event only when the emitter is free
    assign in_ready = !sts.busy;
    assign accept   = in_valid && in_ready;

    i14a_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .sts     (sts),
        .cmd     (cmd)
    );

    i14a_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A status beat always closes its run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == i14a_pkg::K_STATUS |-> out_data.last)
        else $error("status beat without last");

    // A UID byte never closes its run; the ok status beat follows it
    a_uid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == i14a_pkg::K_UID |-> !out_data.last)
        else $error("UID beat marked last");

    // Non-status beats carry no status code
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != i14a_pkg::K_STATUS |-> out_data.status == i14a_pkg::ST_OK)
        else $error("status code on data beat");

    // UID count never exceeds the store depth
    a_uid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.uid_count <= 4'(i14a_pkg::UID_DEPTH))
        else $error("UID count out of range");

endmodule
